### sv/spmf_pkg.sv
`default_nettype none

package spmf_pkg;

  // Default sizes of the queue
  localparam int unsigned NUM_LEVELS_DEF  = 4;
  localparam int unsigned LEVEL_DEPTH_DEF = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  // Fixed field widths of the request and response words
  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned ITEM_W   = 16;
  localparam int unsigned LEVEL_W  = 4;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    func_t               func;
    logic [PRIO_W-1:0]   priority_req;
    logic [ITEM_W-1:0]   item_handle;
  } req_word_t;

  typedef struct packed {
    status_t             status;
    logic [ITEM_W-1:0]   popped_handle;
    logic [LEVEL_W-1:0]  popped_level;
  } rsp_word_t;

  // Outcome of one operation, decided in the pointer stage
  typedef struct packed {
    status_t             status;
    logic [LEVEL_W-1:0]  level;
  } meta_t;

endpackage

`default_nettype wire

### sv/spmf_ctrl.sv
`default_nettype none

module spmf_ctrl #(
  parameter int unsigned NUM_LEVELS  = spmf_pkg::NUM_LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF,
  localparam int unsigned LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
  localparam int unsigned IDX_W  = $clog2(LEVEL_DEPTH),
  localparam int unsigned CNT_W  = $clog2(LEVEL_DEPTH + 1),
  localparam int unsigned ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire spmf_pkg::req_word_t req,
  output logic                     wr_en,
  output logic                     rd_en,
  output logic [ADDR_W-1:0]        addr,
  output spmf_pkg::meta_t          meta
);

  logic [IDX_W-1:0] rd_idx [NUM_LEVELS];
  logic [IDX_W-1:0] wr_idx [NUM_LEVELS];
  logic [CNT_W-1:0] cnt    [NUM_LEVELS];

  logic [LVL_W-1:0] push_lvl;
  logic [LVL_W-1:0] pop_lvl;
  logic             pop_hit;
  logic             push_full;
  logic             is_pop;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Clamp the requested priority into a level index
  always_comb begin
    if (req.priority_req == '0) begin
      push_lvl = '0;
    end else if (req.priority_req > spmf_pkg::PRIO_W'(NUM_LEVELS)) begin
      push_lvl = LVL_W'(NUM_LEVELS - 1);
    end else begin
      push_lvl = LVL_W'(req.priority_req - 1'b1);
    end
  end

  // Find the most urgent non-empty level
  always_comb begin
    pop_hit = 1'b0;
    pop_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        pop_hit = 1'b1;
        pop_lvl = LVL_W'(i);
      end
    end
  end

  // Decide the operation and the slot address
  always_comb begin
    is_pop    = (req.func == spmf_pkg::FUNC_POP);
    push_full = (cnt[push_lvl] == CNT_W'(LEVEL_DEPTH));
    wr_en     = accept && !is_pop && !push_full;
    rd_en     = accept && is_pop && pop_hit;
    if (is_pop) begin
      addr = ADDR_W'(ADDR_W'(pop_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(rd_idx[pop_lvl]));
    end else begin
      addr = ADDR_W'(ADDR_W'(push_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(wr_idx[push_lvl]));
    end
    if (is_pop) begin
      if (pop_hit) begin
        meta.status = spmf_pkg::ST_POPPED;
        meta.level  = spmf_pkg::LEVEL_W'(pop_lvl) + 1'b1;
      end else begin
        meta.status = spmf_pkg::ST_EMPTY;
        meta.level  = '0;
      end
    end else begin
      meta.status = push_full ? spmf_pkg::ST_FULL : spmf_pkg::ST_PUSHED;
      meta.level  = '0;
    end
  end

  // Advance the per-level ring pointers and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rd_idx[i] <= '0;
        wr_idx[i] <= '0;
        cnt[i]    <= '0;
      end
    end else begin
      if (wr_en) begin
        wr_idx[push_lvl] <= wrap_inc(wr_idx[push_lvl]);
        cnt[push_lvl]    <= cnt[push_lvl] + 1'b1;
      end
      if (rd_en) begin
        rd_idx[pop_lvl] <= wrap_inc(rd_idx[pop_lvl]);
        cnt[pop_lvl]    <= cnt[pop_lvl] - 1'b1;
      end
    end
  end

  // Check that each level's pointers agree with its fill count
  logic [NUM_LEVELS-1:0] cnt_over;
  logic [NUM_LEVELS-1:0] ptr_mismatch;
  logic [CNT_W:0]        span;

  always_comb begin
    cnt_over     = '0;
    ptr_mismatch = '0;
    span         = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_over[i] = (cnt[i] > CNT_W'(LEVEL_DEPTH));
      if (wr_idx[i] >= rd_idx[i]) begin
        span = (CNT_W + 1)'(wr_idx[i]) - (CNT_W + 1)'(rd_idx[i]);
      end else begin
        span = (CNT_W + 1)'(wr_idx[i]) + (CNT_W + 1)'(LEVEL_DEPTH) - (CNT_W + 1)'(rd_idx[i]);
      end
      ptr_mismatch[i] = !(((CNT_W + 1)'(cnt[i]) == span) ||
                          ((cnt[i] == CNT_W'(LEVEL_DEPTH)) && (span == '0)));
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt_over == '0)
    else $error("fill count beyond level depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst) ptr_mismatch == '0)
    else $error("ring pointers disagree with fill count");

  a_single_port: assert property (@(posedge clk) disable iff (rst) !(wr_en && rd_en))
    else $error("read and write issued together");

endmodule

`default_nettype wire

### sv/spmf_store.sv
`default_nettype none

module spmf_store #(
  parameter int unsigned NUM_LEVELS  = spmf_pkg::NUM_LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = spmf_pkg::HANDLE_BITS_DEF,
  localparam int unsigned ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic                   rd_en,
  input  wire logic [ADDR_W-1:0]      addr,
  input  wire logic [HANDLE_BITS-1:0] wdata,
  output logic [HANDLE_BITS-1:0]      rdata
);

  logic [HANDLE_BITS-1:0] mem [NUM_LEVELS * LEVEL_DEPTH];

  // Single port: write a pushed handle, or read the oldest handle on pop
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### sv/spmf_out.sv
`default_nettype none

module spmf_out #(
  parameter int unsigned NUM_LEVELS  = spmf_pkg::NUM_LEVELS_DEF,
  parameter int unsigned HANDLE_BITS = spmf_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  input  wire spmf_pkg::meta_t        meta,
  input  wire logic [HANDLE_BITS-1:0] rdata,
  input  wire logic                   rsp_stall,
  output logic                        req_stall,
  output logic                        rsp_valid,
  output spmf_pkg::rsp_word_t         rsp
);

  logic                valid_a;
  spmf_pkg::meta_t     meta_a;
  logic                adv_a;
  logic                accept;
  spmf_pkg::rsp_word_t word_a;

  // Result stage moves on when the output register is empty or being taken
  always_comb begin
    adv_a     = valid_a && (!rsp_valid || !rsp_stall);
    req_stall = valid_a && !adv_a;
    accept    = req_valid && !req_stall;
  end

  // Build the response word; only a successful pop carries a handle
  always_comb begin
    word_a.status       = meta_a.status;
    word_a.popped_level = meta_a.level;
    if (meta_a.status == spmf_pkg::ST_POPPED) begin
      word_a.popped_handle = spmf_pkg::ITEM_W'(64'(rdata));
    end else begin
      word_a.popped_handle = '0;
    end
  end

  // Hold the result stage and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        valid_a <= 1'b1;
      end else if (adv_a) begin
        valid_a <= 1'b0;
      end
      if (adv_a) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      meta_a <= meta;
    end
    if (adv_a) begin
      rsp <= word_a;
    end
  end

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && (rsp.status != spmf_pkg::ST_POPPED)
      |-> (rsp.popped_handle == '0) && (rsp.popped_level == '0))
    else $error("non-pop word carries a handle or level");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && (rsp.status == spmf_pkg::ST_POPPED)
      |-> (rsp.popped_level != '0) &&
          (rsp.popped_level <= spmf_pkg::LEVEL_W'(NUM_LEVELS)))
    else $error("popped level out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
      req_stall |-> valid_a && rsp_valid && rsp_stall)
    else $error("request stalled without a blocked result");

endmodule

`default_nettype wire

### sv/strict_priority_multi_fifo.sv
`default_nettype none

// Strict-priority queue of item handles: one ring buffer of LEVEL_DEPTH
// handles per level, NUM_LEVELS levels, level 1 the most urgent. A push
// clamps its priority into 1..NUM_LEVELS and appends the handle, or is
// dropped with status full when that level is full. A pop takes the oldest
// handle of the most urgent non-empty level and returns it with its level,
// or returns status empty. Every request word yields one response word.
// One request is accepted every cycle while responses are being taken; the
// response word passes through the result stage and the output register. A
// request stalls only while a finished word waits behind a stalled response.
// The single-port handle memory, used for either the push write or the pop
// read, allows one operation per cycle. The memory needs no clearing after
// reset: reset empties every level through its pointers.
module strict_priority_multi_fifo #(
  parameter int unsigned NUM_LEVELS  = spmf_pkg::NUM_LEVELS_DEF,
  parameter int unsigned LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = spmf_pkg::HANDLE_BITS_DEF,
  localparam int unsigned ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire spmf_pkg::req_word_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output spmf_pkg::rsp_word_t      rsp
);

  logic                   accept;
  logic                   wr_en;
  logic                   rd_en;
  logic [ADDR_W-1:0]      addr;
  logic [HANDLE_BITS-1:0] wdata;
  logic [HANDLE_BITS-1:0] rdata;
  spmf_pkg::meta_t        meta;

  // Take a word whenever the result stage can make room
  assign accept = req_valid && !req_stall;

  // Keep the handle in its low HANDLE_BITS bits
  assign wdata = HANDLE_BITS'(64'(req.item_handle));

  spmf_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .wr_en  (wr_en),
    .rd_en  (rd_en),
    .addr   (addr),
    .meta   (meta)
  );

  spmf_store #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_store (
    .clk   (clk),
    .wr_en (wr_en),
    .rd_en (rd_en),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  spmf_out #(
    .NUM_LEVELS  (NUM_LEVELS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .meta      (meta),
    .rdata     (rdata),
    .rsp_stall (rsp_stall),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### tb/spmf_queue_monitor.sv
`default_nettype none

module spmf_queue_monitor
  import spmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  input  wire logic        req_stall,
  input  wire req_word_t   req,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_stall,
  input  wire rsp_word_t   rsp,
  output int unsigned      mismatches,
  output int unsigned      awaited
);

  localparam int unsigned LEVELS = NUM_LEVELS_DEF;
  localparam int unsigned DEPTH  = LEVEL_DEPTH_DEF;

  // Shadow copy of the per-level ring buffers
  logic [ITEM_W-1:0] level_slots [LEVELS][DEPTH];
  int unsigned       oldest_slot [LEVELS];
  int unsigned       free_slot   [LEVELS];
  int unsigned       level_fill  [LEVELS];

  // Response words still owed by the block, oldest first
  rsp_word_t         owed_rsp [$];
  int unsigned       miss_total;

  initial begin
    miss_total = 0;
  end

  // Apply one request word to the shadow queue and return the response it earns
  function automatic rsp_word_t queue_outcome(input req_word_t r);
    rsp_word_t   o;
    int unsigned lvl;
    bit          found;
    o.status        = ST_EMPTY;
    o.popped_handle = '0;
    o.popped_level  = '0;
    found           = 1'b0;
    if (r.func == FUNC_PUSH) begin
      // clamp the requested priority into 1..LEVELS, then index from zero
      if (r.priority_req == 0) begin
        lvl = 0;
      end else if (r.priority_req > LEVELS) begin
        lvl = LEVELS - 1;
      end else begin
        lvl = r.priority_req - 1;
      end
      if (level_fill[lvl] >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        level_slots[lvl][free_slot[lvl]] = r.item_handle;
        free_slot[lvl]  = (free_slot[lvl] + 1) % DEPTH;
        level_fill[lvl] = level_fill[lvl] + 1;
        o.status = ST_PUSHED;
      end
    end else begin
      // take the oldest handle of the most urgent level holding one
      for (int l = 0; l < LEVELS && !found; l++) begin
        if (level_fill[l] != 0) begin
          o.popped_handle = level_slots[l][oldest_slot[l]];
          o.popped_level  = LEVEL_W'(l + 1);
          oldest_slot[l]  = (oldest_slot[l] + 1) % DEPTH;
          level_fill[l]   = level_fill[l] - 1;
          o.status        = ST_POPPED;
          found           = 1'b1;
        end
      end
    end
    return o;
  endfunction

  // Compare each accepted response, then record what each accepted request owes
  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        oldest_slot[l] = 0;
        free_slot[l]   = 0;
        level_fill[l]  = 0;
      end
      owed_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp.size() == 0) begin
          if (miss_total < 10) begin
            $display("unexpected response word: status=%0d handle=%h level=%0d",
                     rsp.status, rsp.popped_handle, rsp.popped_level);
          end
          miss_total = miss_total + 1;
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.status !== want.status || rsp.popped_handle !== want.popped_handle ||
              rsp.popped_level !== want.popped_level) begin
            if (miss_total < 10) begin
              $display({"response mismatch: want status=%0d handle=%h level=%0d,",
                        " got status=%0d handle=%h level=%0d"},
                       want.status, want.popped_handle, want.popped_level,
                       rsp.status, rsp.popped_handle, rsp.popped_level);
            end
            miss_total = miss_total + 1;
          end
        end
      end
      if (req_valid && !req_stall) begin
        owed_rsp.push_back(queue_outcome(req));
      end
    end
    mismatches <= miss_total;
    awaited    <= owed_rsp.size();
  end

endmodule

`default_nettype wire

### tb/tb_strict_priority_multi_fifo.sv
`default_nettype none

module tb_strict_priority_multi_fifo;
  import spmf_pkg::*;

  localparam int unsigned WORD_COUNT     = 1100;
  localparam int unsigned CALM_FROM      = 950;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_AFTER     = 100;
  localparam int unsigned HOLD_CYCLES    = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_word_t   req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_word_t   rsp;

  int unsigned words_sent   = 0;
  int unsigned words_back   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count;
  int unsigned awaited_count;
  bit          calm         = 1'b0;

  strict_priority_multi_fifo DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  spmf_queue_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .mismatches (fail_count),
    .awaited    (awaited_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic req_word_t word_of(input func_t f, input logic [PRIO_W-1:0] p,
                                        input logic [ITEM_W-1:0] h);
    req_word_t w;
    w.func         = f;
    w.priority_req = p;
    w.item_handle  = h;
    return w;
  endfunction

  // Offer one word, possibly after an idle burst, and hold it until taken
  task automatic put_word(input req_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent = words_sent + 1;
  endtask

  // Stimulus: directed words, then random segments, then drain
  initial begin
    int unsigned mode;
    int unsigned run;
    int unsigned push_pct;
    int unsigned lvl;
    logic [PRIO_W-1:0] prio;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // pop on an empty queue, then clamped and in-range pushes to every level
    put_word(word_of(FUNC_POP,  4'h0, 16'h0000));
    put_word(word_of(FUNC_PUSH, 4'h0, 16'hFFFF));
    put_word(word_of(FUNC_PUSH, 4'hF, 16'h0000));
    put_word(word_of(FUNC_PUSH, 4'h1, 16'h0001));
    put_word(word_of(FUNC_PUSH, 4'h2, 16'h8000));
    put_word(word_of(FUNC_PUSH, 4'h3, 16'h5555));
    put_word(word_of(FUNC_PUSH, 4'h4, 16'hAAAA));
    put_word(word_of(FUNC_PUSH, 4'h5, 16'h1234));
    put_word(word_of(FUNC_PUSH, 4'h8, 16'h00FF));
    // drain in priority order and pop once more on empty
    repeat (9) put_word(word_of(FUNC_POP, 4'hF, 16'hFFFF));
    put_word(word_of(FUNC_PUSH, 4'h2, 16'h7E81));
    put_word(word_of(FUNC_POP,  4'h0, 16'h0000));

    // random segments: mixed traffic, level fills past full, and drains
    while (words_sent < WORD_COUNT) begin
      calm = (words_sent >= CALM_FROM);
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        push_pct = 25 * $urandom_range(1, 3);
        run      = $urandom_range(10, 40);
        repeat (run) begin
          put_word(word_of(func_t'(($urandom_range(1, 100) <= push_pct) ? FUNC_PUSH : FUNC_POP),
                           PRIO_W'($urandom_range(0, 15)), ITEM_W'($urandom())));
        end
      end else if (mode < 8) begin
        lvl = $urandom_range(1, NUM_LEVELS_DEF);
        run = $urandom_range(LEVEL_DEPTH_DEF + 1, LEVEL_DEPTH_DEF + 4);
        repeat (run) begin
          if (lvl == 1) begin
            prio = PRIO_W'($urandom_range(0, 1));
          end else if (lvl == NUM_LEVELS_DEF) begin
            prio = PRIO_W'($urandom_range(NUM_LEVELS_DEF, 15));
          end else begin
            prio = PRIO_W'(lvl);
          end
          put_word(word_of(FUNC_PUSH, prio, ITEM_W'($urandom())));
        end
      end else begin
        run = $urandom_range(20, 70);
        repeat (run) begin
          put_word(word_of(FUNC_POP, PRIO_W'($urandom_range(0, 15)), ITEM_W'($urandom())));
        end
      end
    end
    req_valid <= 1'b0;

    // wait for every owed response, then keep watching for stray words
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stall bursts, with one long hold-off to fill the block
  initial begin
    bit held_off;
    held_off = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held_off && words_back >= HOLD_AFTER) begin
        held_off = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Count returned words and stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      words_back <= words_back + 1;
    end
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

### files.f
sv/spmf_pkg.sv
sv/spmf_ctrl.sv
sv/spmf_store.sv
sv/spmf_out.sv
sv/strict_priority_multi_fifo.sv
tb/spmf_queue_monitor.sv
tb/tb_strict_priority_multi_fifo.sv
